FILE: src/ssort_pkg.sv
// Shared types for the stable merge sorter: item structs and control/status bundles.
package ssort_pkg;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      final_item;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_list;
        logic                      overflow;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic pass_start;
        logic pass_next;
        logic run_start;
        logic merge_step;
        logic out_start;
        logic out_fill;
        logic out_hold;
    } cmd_t;

    typedef struct packed {
        logic load_final;
        logic pass_over;
        logic list_over;
        logic run_last;
        logic out_taken;
        logic out_last;
    } status_t;

endpackage

FILE: src/ssort_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module ssort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: src/ssort_ctrl.sv
// Sequencer for load, merge passes and output of the stable merge sorter.
module ssort_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  ssort_pkg::status_t status,
    output ssort_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_LOAD      = 7'b0000001,
        S_SORT_INIT = 7'b0000010,
        S_PASS      = 7'b0000100,
        S_RUN       = 7'b0001000,
        S_MERGE     = 7'b0010000,
        S_OUT_FILL  = 7'b0100000,
        S_OUT_HOLD  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (status.load_final)
                begin
                    state_next = S_SORT_INIT;
                end
            end
            S_SORT_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = S_PASS;
            end
            S_PASS:
            begin
                if (status.pass_over)
                begin
                    cmd.out_start = 1'b1;
                    state_next    = S_OUT_FILL;
                end
                else
                begin
                    cmd.pass_start = 1'b1;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                if (status.list_over)
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = S_PASS;
                end
                else
                begin
                    cmd.run_start = 1'b1;
                    state_next    = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge_step = 1'b1;
                if (status.run_last)
                begin
                    state_next = S_RUN;
                end
            end
            S_OUT_FILL:
            begin
                cmd.out_fill = 1'b1;
                state_next   = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                cmd.out_hold = 1'b1;
                if (status.out_taken)
                begin
                    state_next = status.out_last ? S_LOAD : S_OUT_FILL;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

FILE: src/ssort_dp.sv
// Datapath: element store, merge buffer, run counters, merge compare and output register.
module ssort_dp #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssort_pkg::cmd_t       cmd,
    output ssort_pkg::status_t    status,
    input  logic                  load_valid,
    input  ssort_pkg::in_item_t   load_item,
    output logic                  sort_valid,
    input  logic                  sort_stall,
    output ssort_pkg::out_item_t  sort_item
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;
    localparam int VW = ssort_pkg::VALUE_W;

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [WW-1:0] width_reg, width_next;
    logic          src_sel_reg, src_sel_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    ssort_pkg::out_item_t out_item_reg, out_item_next;

    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [AW-1:0] wr_addr;
    logic [VW-1:0] wr_data;
    logic          store_we, merge_we;
    logic [VW-1:0] ram0_rd_a, ram0_rd_b, ram1_rd_a, ram1_rd_b;
    logic [VW-1:0] da, db;
    logic [SW-1:0] mid_sum, hi_sum;
    logic [CW-1:0] mid_new, hi_new;
    logic          i_ok, j_ok, take_a;
    logic          load_acc, out_taken;

    ssort_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_store (
        .clk     (clk),
        .we      (store_we || (merge_we && src_sel_reg)),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (ram0_rd_a),
        .rdata_b (ram0_rd_b)
    );

    ssort_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_buffer (
        .clk     (clk),
        .we      (merge_we && !src_sel_reg),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (ram1_rd_a),
        .rdata_b (ram1_rd_b)
    );

    assign da = src_sel_reg ? ram1_rd_a : ram0_rd_a;
    assign db = src_sel_reg ? ram1_rd_b : ram0_rd_b;

    // Run bounds, clamped to the list length.
    assign mid_sum = SW'(lo_reg) + SW'(width_reg);
    assign hi_sum  = SW'(lo_reg) + SW'({width_reg, 1'b0});
    assign mid_new = (mid_sum > SW'(count_reg)) ? count_reg : mid_sum[CW-1:0];
    assign hi_new  = (hi_sum > SW'(count_reg)) ? count_reg : hi_sum[CW-1:0];

    // Left run wins ties.
    assign i_ok   = i_reg < mid_reg;
    assign j_ok   = j_reg < hi_reg;
    assign take_a = i_ok && (!j_ok || ($signed(da) <= $signed(db)));

    assign load_acc  = cmd.load && load_valid;
    assign out_taken = cmd.out_hold && out_valid_reg && !sort_stall;

    assign status.load_final = load_acc && load_item.final_item;
    assign status.pass_over  = width_reg >= WW'(count_reg);
    assign status.list_over  = lo_reg >= count_reg;
    assign status.run_last   = (k_reg + CW'(1)) == hi_reg;
    assign status.out_taken  = out_taken;
    assign status.out_last   = (k_reg + CW'(1)) == count_reg;

    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        width_next     = width_reg;
        src_sel_next   = src_sel_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        rd_addr_a      = i_reg[AW-1:0];
        rd_addr_b      = j_reg[AW-1:0];
        wr_addr        = k_reg[AW-1:0];
        wr_data        = take_a ? da : db;
        store_we       = 1'b0;
        merge_we       = 1'b0;

        if (load_acc)
        begin
            wr_addr = count_reg[AW-1:0];
            wr_data = load_item.value;
            if (count_reg < CW'(MAX_ELEMENTS))
            begin
                store_we   = 1'b1;
                count_next = count_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (cmd.sort_init)
        begin
            width_next   = WW'(1);
            src_sel_next = 1'b0;
        end

        if (cmd.pass_start)
        begin
            lo_next = '0;
        end

        if (cmd.pass_next)
        begin
            width_next   = {width_reg[WW-2:0], 1'b0};
            src_sel_next = !src_sel_reg;
        end

        if (cmd.run_start)
        begin
            mid_next  = mid_new;
            hi_next   = hi_new;
            i_next    = lo_reg;
            j_next    = mid_new;
            k_next    = lo_reg;
            rd_addr_a = lo_reg[AW-1:0];
            rd_addr_b = mid_new[AW-1:0];
        end

        if (cmd.merge_step)
        begin
            merge_we  = 1'b1;
            i_next    = i_reg + CW'(take_a);
            j_next    = j_reg + CW'(!take_a);
            k_next    = k_reg + CW'(1);
            rd_addr_a = i_next[AW-1:0];
            rd_addr_b = j_next[AW-1:0];
            if (status.run_last)
            begin
                lo_next = hi_reg;
            end
        end

        if (cmd.out_start)
        begin
            k_next    = '0;
            rd_addr_a = '0;
        end

        if (cmd.out_fill)
        begin
            out_item_next.sorted_value = da;
            out_item_next.end_of_list  = status.out_last;
            out_item_next.overflow     = dropped_reg;
            out_valid_next             = 1'b1;
        end

        if (out_taken)
        begin
            out_valid_next = 1'b0;
            if (status.out_last)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                k_next    = k_reg + CW'(1);
                rd_addr_a = k_next[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg    <= width_next;
        src_sel_reg  <= src_sel_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        out_item_reg <= out_item_next;
    end

    assign sort_valid = out_valid_reg;
    assign sort_item  = out_item_reg;

endmodule

FILE: src/stable_merge_sorter.sv
// Top level of the stable merge sorter: controller, datapath and port wiring.
//
// Load channel (load_valid, load_stall, load_item): one signed value per item.
// load_stall is low while the block collects a list; an item with final_item
// set ends the list. Up to MAX_ELEMENTS values are kept; later ones are
// dropped and every item of that list's output carries overflow.
// Sort channel (sort_valid, sort_stall, sort_item): the values in ascending
// order, equal values in load order, end_of_list on the last one.
// Each item with load_valid high is taken while collecting. After the final
// item, the sort runs ceil(log2(n)) merge passes through one compare unit that
// places one element per cycle, with a setup step before each run and before
// each pass, alternating between two dual-read RAMs. Output then reads each item
// from the RAM into the output register, and reads the next one only after
// that item is taken. load_stall stays high from the final item until the last
// output item is taken. While sort_stall is high the output register holds
// its item and the sequencer waits. Reset returns the block to collecting
// an empty list; the RAMs need no clearing.
module stable_merge_sorter #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    output logic                 load_stall,
    input  ssort_pkg::in_item_t  load_item,
    output logic                 sort_valid,
    input  logic                 sort_stall,
    output ssort_pkg::out_item_t sort_item
);

    ssort_pkg::cmd_t    cmd;
    ssort_pkg::status_t status;

    ssort_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    ssort_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .load_valid (load_valid),
        .load_item  (load_item),
        .sort_valid (sort_valid),
        .sort_stall (sort_stall),
        .sort_item  (sort_item)
    );

    assign load_stall = !cmd.load;

endmodule

FILE: src/ssort_checker.sv
// Port-level checks for the stable merge sorter, bound to the top level.
module ssort_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 load_valid,
    input logic                 load_stall,
    input ssort_pkg::in_item_t  load_item,
    input logic                 sort_valid,
    input logic                 sort_stall,
    input ssort_pkg::out_item_t sort_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sort_valid && sort_stall |=> sort_valid && $stable(sort_item))
        else $error("stalled output item changed");

    a_no_out_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
        !load_stall |-> !sort_valid)
        else $error("output item shown while collecting");

    a_final_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && !load_stall && load_item.final_item |=> load_stall)
        else $error("load still open after final item");

    a_last_reopens_load: assert property (@(posedge clk) disable iff (!rst_n)
        sort_valid && !sort_stall && sort_item.end_of_list |=> !load_stall)
        else $error("load not reopened after last output item");

    a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
        sort_valid && !sort_stall && !sort_item.end_of_list ##2
        sort_valid |-> sort_item.overflow == $past(sort_item.overflow, 2))
        else $error("overflow flag changed within a list");

endmodule

bind stable_merge_sorter ssort_checker u_ssort_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_stall (load_stall),
    .load_item  (load_item),
    .sort_valid (sort_valid),
    .sort_stall (sort_stall),
    .sort_item  (sort_item)
);

FILE: tb/sv/stable_merge_sorter_test.sv
// Self-checking testbench for stable_merge_sorter: random lists, stable sort prediction.
`timescale 1ns / 1ps

module stable_merge_sorter_test;

    localparam int MAX_ELEMENTS = 64;
    localparam int ITEM_TARGET  = 380;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 60;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [ssort_pkg::VALUE_W-1:0] elem_t;

    localparam elem_t MAX_V = 32'sh7FFF_FFFF;
    localparam elem_t MIN_V = elem_t'(32'h8000_0000);

    class sort_scoreboard;
        elem_t                loaded[$];
        bit                   dropped;
        ssort_pkg::out_item_t sorted_q[$];
        int                   capacity;
        int                   errors;

        function new(int cap);
            capacity = cap;
            dropped  = 0;
            errors   = 0;
        endfunction

        function void note_load(ssort_pkg::in_item_t it);
            elem_t                ordered[$];
            ssort_pkg::out_item_t o;
            int                   pos;
            if (loaded.size() < capacity)
                loaded.insert(loaded.size(), it.value);
            else
                dropped = 1;
            if (!it.final_item)
                return;
            foreach (loaded[i])
            begin
                pos = ordered.size();
                while (pos > 0 && ordered[pos-1] > loaded[i])
                    pos--;
                ordered.insert(pos, loaded[i]);
            end
            foreach (ordered[k])
            begin
                o.sorted_value = ordered[k];
                o.end_of_list  = (k == ordered.size() - 1);
                o.overflow     = dropped;
                sorted_q.insert(sorted_q.size(), o);
            end
            loaded.delete();
            dropped = 0;
        endfunction

        function void check_result(ssort_pkg::out_item_t got);
            ssort_pkg::out_item_t want;
            if (sorted_q.size() == 0)
            begin
                $error("unexpected output item: sorted_value %0d", got.sorted_value);
                errors++;
                return;
            end
            want = sorted_q[0];
            sorted_q.delete(0);
            if (got.sorted_value !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                       got.sorted_value);
                errors++;
            end
            if (got.end_of_list !== want.end_of_list)
            begin
                $error("end_of_list: expected %0b, got %0b", want.end_of_list,
                       got.end_of_list);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                errors++;
            end
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 load_valid;
    logic                 load_stall;
    ssort_pkg::in_item_t  load_item;
    logic                 sort_valid;
    logic                 sort_stall;
    ssort_pkg::out_item_t sort_item;

    sort_scoreboard sb;
    bit             idle_on;
    int             items_sent;
    int             results_seen;

    stable_merge_sorter #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_stall (load_stall),
        .load_item  (load_item),
        .sort_valid (sort_valid),
        .sort_stall (sort_stall),
        .sort_item  (sort_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic elem_t pick_value(bit narrow);
        int d;
        d = $urandom_range(0, 8);
        if (narrow)
            return elem_t'(d - 4);
        case ($urandom_range(0, 9))
            0:       return MAX_V;
            1:       return MIN_V;
            2:       return elem_t'(d - 4);
            default: return elem_t'($urandom());
        endcase
    endfunction

    task automatic send_item(input ssort_pkg::in_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            load_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        load_valid <= 1'b1;
        load_item  <= it;
        do
            @(posedge clk);
        while (load_stall);
        sb.note_load(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_list(input elem_t vals[$]);
        ssort_pkg::in_item_t it;
        foreach (vals[i])
        begin
            it.value      = vals[i];
            it.final_item = (i == vals.size() - 1);
            send_item(it);
        end
    endtask

    initial
    begin
        forever
        begin
            int hold;
            @(negedge clk);
            hold = idle_on ? $urandom_range(0, 9) : 0;
            if (results_seen == HOLD_AT)
                hold = LONG_HOLD;
            if (hold > 0)
            begin
                sort_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            sort_stall <= 1'b0;
            do
                @(posedge clk);
            while (!sort_valid);
            sb.check_result(sort_item);
            results_seen++;
        end
    end

    initial
    begin
        elem_t vals[$];
        int    list_no;
        int    len;
        bit    narrow;

        sb           = new(MAX_ELEMENTS);
        rst_n        = 1'b0;
        load_valid   = 1'b0;
        load_item    = '0;
        sort_stall   = 1'b0;
        idle_on      = 1'b1;
        items_sent   = 0;
        results_seen = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        vals = {MAX_V};
        send_list(vals);
        vals = {MIN_V};
        send_list(vals);
        vals = {elem_t'(5), elem_t'(-5)};
        send_list(vals);
        vals = {elem_t'(0), elem_t'(-1), MAX_V, MIN_V, elem_t'(0), elem_t'(1), elem_t'(-1),
                MIN_V};
        send_list(vals);
        vals = {elem_t'(7), elem_t'(7), elem_t'(7)};
        send_list(vals);
        vals = {elem_t'(3), elem_t'(1), elem_t'(2), elem_t'(1), elem_t'(3), elem_t'(0)};
        send_list(vals);

        list_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            narrow  = ($urandom_range(0, 2) == 0);
            case (list_no)
                2:       len = MAX_ELEMENTS;
                4:       len = MAX_ELEMENTS + 1;
                6:       len = MAX_ELEMENTS + 5;
                default:
                    case ($urandom_range(0, 9))
                        8:       len = MAX_ELEMENTS;
                        9:       len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 8);
                        default: len = $urandom_range(1, 12);
                    endcase
            endcase
            vals.delete();
            repeat (len) vals.insert(vals.size(), pick_value(narrow));
            send_list(vals);
            if (list_no == 3)
            begin
                load_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            list_no++;
        end

        load_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/ssort_pkg.sv
src/ssort_ram.sv
src/ssort_ctrl.sv
src/ssort_dp.sv
src/stable_merge_sorter.sv
src/ssort_checker.sv
tb/sv/stable_merge_sorter_test.sv
